// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file of the ipv4 option walker
// no dependencies; simulation only, empty bodies under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define OTW_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("otw assertion failed");

// expression must never be true outside reset
`define OTW_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("otw forbidden condition seen");

`else

`define OTW_ASSERT(lbl, clk, rstn, prop)
`define OTW_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: hdl/otw_pkg.sv
// types and constants for the ipv4 option walker
// used by otw_step and ipv4_option_tlv_walker; no dependencies
`default_nettype none

package otw_pkg;

	localparam int MAX_AREA_BYTES = 40;

	typedef enum logic [1:0] {
		ROLE_TYPE   = 2'd0,
		ROLE_LENGTH = 2'd1,
		ROLE_DATA   = 2'd2,
		ROLE_NONE   = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_SHORT_LEN = 2'd1,
		STAT_OVERRUN   = 2'd2
	} status_t;

	typedef struct packed {
		logic [5:0] byte_offset;
		logic [5:0] area_size;
		logic [7:0] current_type;
		logic [5:0] bytes_left;
		logic       expect_length;
		logic [5:0] data_counter;
		logic [5:0] data_size;
		status_t    stop_status;
	} walk_state_t;

	typedef struct packed {
		logic [7:0] option_type;
		role_t      byte_role;
		logic [5:0] data_index;
		logic [5:0] data_size;
		logic       option_end;
		status_t    parse_status;
		logic       area_end;
	} walk_result_t;

endpackage

`default_nettype wire

// File: hdl/otw_step.sv
// per-byte decision of the option walker: next state and tagged result
// depends on otw_pkg
`default_nettype none

module otw_step (
	input  otw_pkg::walk_state_t  cur_st,
	input  logic [7:0]            data_byte,
	input  logic                  area_start,
	input  logic [5:0]            area_length,
	output otw_pkg::walk_state_t  nxt_st,
	output otw_pkg::walk_result_t res
);
	import otw_pkg::*;

	walk_state_t st;
	logic        last;
	logic [8:0]  span;

	always_comb begin
		st = cur_st;
		if (area_start) begin
			st = '0;
			if ({2'b00, area_length} < 8'(MAX_AREA_BYTES)) begin
				st.area_size = area_length;
			end else begin
				st.area_size = 6'(MAX_AREA_BYTES);
			end
		end

		last = (st.byte_offset + 6'd1) == st.area_size;
		// option end position measured from its type byte one back
		span = {3'b000, st.byte_offset} - 9'd1 + {1'b0, data_byte};

		nxt_st           = st;
		res.option_type  = '0;
		res.byte_role    = ROLE_NONE;
		res.data_index   = '0;
		res.data_size    = '0;
		res.option_end   = 1'b0;
		res.parse_status = st.stop_status;
		res.area_end     = 1'b0;

		if (st.byte_offset < st.area_size) begin
			nxt_st.byte_offset = st.byte_offset + 6'd1;
			res.area_end       = last;
			if (st.stop_status != STAT_OK) begin
				res.byte_role = ROLE_NONE;
			end else if (st.expect_length) begin
				nxt_st.expect_length = 1'b0;
				res.option_type      = st.current_type;
				res.byte_role        = ROLE_LENGTH;
				if (data_byte < 8'd2) begin
					nxt_st.stop_status = STAT_SHORT_LEN;
					res.parse_status   = STAT_SHORT_LEN;
				end else if (span > {3'b000, st.area_size}) begin
					nxt_st.stop_status = STAT_OVERRUN;
					res.parse_status   = STAT_OVERRUN;
				end else begin
					nxt_st.data_size    = 6'(data_byte - 8'd2);
					nxt_st.bytes_left   = 6'(data_byte - 8'd2);
					nxt_st.data_counter = '0;
					res.data_size       = 6'(data_byte - 8'd2);
					res.option_end      = data_byte == 8'd2;
				end
			end else if (st.bytes_left != '0) begin
				nxt_st.data_counter = st.data_counter + 6'd1;
				nxt_st.bytes_left   = st.bytes_left - 6'd1;
				res.option_type     = st.current_type;
				res.byte_role       = ROLE_DATA;
				res.data_index      = st.data_counter;
				res.data_size       = st.data_size;
				res.option_end      = st.bytes_left == 6'd1;
			end else begin
				// type byte
				nxt_st.current_type = data_byte;
				nxt_st.data_size    = '0;
				nxt_st.data_counter = '0;
				res.option_type     = data_byte;
				res.byte_role       = ROLE_TYPE;
				if (data_byte == 8'd0 || data_byte == 8'd1) begin
					res.option_end = 1'b1;
				end else if (last) begin
					nxt_st.stop_status = STAT_OVERRUN;
					res.parse_status   = STAT_OVERRUN;
				end else begin
					nxt_st.expect_length = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/ipv4_option_tlv_walker.sv
// top level of the ipv4 option walker: input register, parse state, result register
// depends on otw_pkg, otw_step and assert_macros.svh
//
// usage
//  s_axis carries one option-area byte per word; tuser flags the first byte of an
//  area, whose tdata also holds the area length (clipped to MAX_AREA_BYTES)
//  m_axis returns one tagged word per input word, in order; tlast marks the
//  last byte of the area, tuser gives the byte role
//  a word accepted on s_axis passes the input register, then the result register, to m_axis
//  throughput: one word per cycle while m_axis does not stall; the parse state feeds
//  back through one short decision stage, so every such cycle can take a word
//  s_axis_tready stays high while the result register is empty or being taken;
//  when m_axis stalls, one word waits in the input register and one in the
//  result register, then s_axis_tready drops
//  reset clears both stages and the parse state; bytes before the first area
//  start come out tagged not parsed
`default_nettype none

module ipv4_option_tlv_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // data_byte, area_length, zero pad
	input  logic        s_axis_tuser,  // area_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // option_type, data_index, data_size,
	                                   // option_end, parse_status, zero pad
	output logic [1:0]  m_axis_tuser,  // byte_role
	output logic        m_axis_tlast   // area_end
);
	import otw_pkg::*;

	`include "assert_macros.svh"

	logic         valid_s1;
	logic [7:0]   data_byte_s1;
	logic         area_start_s1;
	logic [5:0]   area_length_s1;
	logic         valid_s2;
	walk_result_t res_s2;
	walk_state_t  st_q;
	walk_state_t  st_next;
	walk_result_t res_next;
	logic         adv_s2;

	assign adv_s2        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s2;

	otw_step u_step (
		.cur_st      (st_q),
		.data_byte   (data_byte_s1),
		.area_start  (area_start_s1),
		.area_length (area_length_s1),
		.nxt_st      (st_next),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				st_q     <= st_next;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_byte_s1   <= s_axis_tdata[7:0];
			area_length_s1 <= s_axis_tdata[13:8];
			area_start_s1  <= s_axis_tuser;
		end
		if (adv_s2) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2.parse_status, res_s2.option_end, res_s2.data_size,
		res_s2.data_index, res_s2.option_type};
	assign m_axis_tuser  = res_s2.byte_role;
	assign m_axis_tlast  = res_s2.area_end;

	`OTW_ASSERT(a_offset_in_area, clk, arst_n, st_q.byte_offset <= st_q.area_size)
	`OTW_NEVER(a_stop_while_length, clk, arst_n,
		st_q.stop_status != STAT_OK && st_q.expect_length)
	`OTW_NEVER(a_data_while_length, clk, arst_n, st_q.bytes_left != '0 && st_q.expect_length)
	`OTW_ASSERT(a_left_within_size, clk, arst_n, st_q.bytes_left <= st_q.data_size)
	`OTW_ASSERT(a_unparsed_is_blank, clk, arst_n,
		(valid_s2 && res_s2.byte_role == ROLE_NONE) |->
		(res_s2.option_type == 8'd0 && !res_s2.option_end && res_s2.data_size == 6'd0))

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for ipv4_option_tlv_walker: streams option-area bytes in,
// predicts every tagged output word and compares it field by field
// depends on otw_pkg and the walker rtl

module tb_top;
	import otw_pkg::*;

	localparam logic [7:0] OPT_EOL = 8'h00;
	localparam logic [7:0] OPT_NOP = 8'h01;
	localparam int MIN_OPT_LEN = 2;

	localparam logic [1:0] PH_SLOW_SINK   = 2'd0;
	localparam logic [1:0] PH_SLOW_SOURCE = 2'd1;
	localparam logic [1:0] PH_FULL_RATE   = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic [5:0] alen;
		logic       hold;
		logic [1:0] phase;
	} area_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // data_byte, area_length, zero pad
	logic        s_axis_tuser = 1'b0;  // area_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // option_type, data_index, data_size, option_end, parse_status
	logic [1:0]  m_axis_tuser;  // byte_role
	logic        m_axis_tlast;  // area_end

	area_word_t   area_bytes_q[$];
	walk_result_t tagged_q[$];
	logic         in_fire = 1'b0;
	logic [1:0]   cur_phase = PH_SLOW_SINK;
	int           error_count = 0;

	// predicted walk state
	logic [5:0] walk_offset = '0;
	logic [5:0] walk_area = '0;
	logic [7:0] walk_type = '0;
	logic [7:0] walk_left = '0;
	logic       walk_want_len = 1'b0;
	logic [5:0] walk_index = '0;
	logic [5:0] walk_size = '0;
	status_t    walk_stop = STAT_OK;

	ipv4_option_tlv_walker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	function automatic walk_result_t walk_byte(logic [7:0] b, logic start, logic [5:0] alen);
		walk_result_t r;
		int pos;
		logic last;
		r = '0;
		r.byte_role = ROLE_NONE;
		if (start) begin
			walk_area = (alen < MAX_AREA_BYTES) ? alen : 6'(MAX_AREA_BYTES);
			walk_offset = '0;
			walk_type = '0;
			walk_left = '0;
			walk_want_len = 1'b0;
			walk_index = '0;
			walk_size = '0;
			walk_stop = STAT_OK;
		end
		r.parse_status = walk_stop;
		if (walk_offset >= walk_area)
			return r;
		pos = int'(walk_offset);
		last = (pos + 1 == int'(walk_area));
		walk_offset = 6'(pos + 1);
		r.area_end = last;
		if (walk_stop != STAT_OK)
			return r;
		r.option_type = walk_type;
		if (walk_want_len) begin
			walk_want_len = 1'b0;
			r.byte_role = ROLE_LENGTH;
			if (b < MIN_OPT_LEN) begin
				walk_stop = STAT_SHORT_LEN;
				r.parse_status = walk_stop;
			end else if (pos - 1 + int'(b) > int'(walk_area)) begin
				walk_stop = STAT_OVERRUN;
				r.parse_status = walk_stop;
			end else begin
				walk_size = 6'(b - MIN_OPT_LEN);
				walk_left = 8'(b - MIN_OPT_LEN);
				walk_index = '0;
				r.data_size = walk_size;
				r.option_end = (walk_left == 0);
			end
			return r;
		end
		if (walk_left != 0) begin
			r.byte_role = ROLE_DATA;
			r.data_index = walk_index;
			walk_index = walk_index + 6'd1;
			walk_left = walk_left - 8'd1;
			r.data_size = walk_size;
			r.option_end = (walk_left == 0);
			return r;
		end
		walk_type = b;
		walk_size = '0;
		walk_index = '0;
		r.option_type = b;
		r.byte_role = ROLE_TYPE;
		if (b == OPT_EOL || b == OPT_NOP)
			r.option_end = 1'b1;
		else if (last) begin
			walk_stop = STAT_OVERRUN;
			r.parse_status = walk_stop;
		end else
			walk_want_len = 1'b1;
		return r;
	endfunction

	task automatic push_byte(logic [7:0] data, logic start, logic [5:0] alen,
			logic hold = 1'b0, logic [1:0] phase = PH_SLOW_SINK);
		area_word_t w;
		w.data = data;
		w.start = start;
		w.alen = alen;
		w.hold = hold;
		w.phase = phase;
		area_bytes_q.push_back(w);
	endtask

	// one option area: mostly well-formed options with random content,
	// some with a bad or overlong length, some cut short or followed by stray bytes
	task automatic add_random_area(logic [1:0] phase, logic hold);
		logic [7:0] body[$];
		int alen, span, rem, len, pick, cut;
		bit broken;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			alen = 0;
		else if (pick < 15)
			alen = $urandom_range(41, 63);
		else
			alen = $urandom_range(1, 40);
		span = (alen < MAX_AREA_BYTES) ? alen : MAX_AREA_BYTES;
		broken = ($urandom_range(0, 99) < 25);
		if (broken && $urandom_range(0, 3) == 0) begin
			repeat (span) body.push_back(8'($urandom));
		end else begin
			while (body.size() < span) begin
				rem = span - body.size();
				if (rem == 1 || $urandom_range(0, 4) == 0) begin
					if (rem == 1 && broken && $urandom_range(0, 1) == 1)
						body.push_back(8'($urandom_range(2, 255)));
					else
						body.push_back(8'($urandom_range(0, 1)));
				end else if (broken && $urandom_range(0, 3) == 0) begin
					body.push_back(8'($urandom_range(2, 255)));
					if ($urandom_range(0, 1) == 0)
						body.push_back(8'($urandom_range(0, 1)));
					else
						body.push_back(8'($urandom_range(rem + 1, 255)));
					while (body.size() < span)
						body.push_back(8'($urandom));
				end else begin
					if ($urandom_range(0, 3) == 0)
						len = $urandom_range(2, rem);
					else
						len = $urandom_range(2, (rem < 8) ? rem : 8);
					body.push_back(8'($urandom_range(2, 255)));
					body.push_back(8'(len));
					repeat (len - 2) body.push_back(8'($urandom));
				end
			end
		end
		if (span == 0)
			repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
		if (body.size() > 1 && $urandom_range(0, 19) == 0) begin
			cut = $urandom_range(1, body.size() - 1);
			while (body.size() > cut)
				void'(body.pop_back());
		end else if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
		foreach (body[i])
			push_byte(body[i], i == 0, (i == 0) ? 6'(alen) : 6'($urandom_range(0, 63)),
				hold && i == 0, phase);
	endtask

	// driver
	always @(negedge clk) begin
		area_word_t nxt;
		int idle_pct;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			idle_pct = 0;
			if (area_bytes_q.size() > 0) begin
				if (area_bytes_q[0].phase == PH_SLOW_SINK)
					idle_pct = 37;
				else if (area_bytes_q[0].phase == PH_SLOW_SOURCE)
					idle_pct = 78;
			end
			if (area_bytes_q.size() > 0 && !(area_bytes_q[0].hold && tagged_q.size() > 0)
					&& $urandom_range(0, 99) >= idle_pct) begin
				nxt = area_bytes_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {2'b00, nxt.alen, nxt.data};
				s_axis_tuser <= nxt.start;
				cur_phase <= nxt.phase;
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (cur_phase == PH_SLOW_SINK)
			m_axis_tready <= ($urandom_range(0, 99) >= 78);
		else if (cur_phase == PH_SLOW_SOURCE)
			m_axis_tready <= ($urandom_range(0, 99) >= 37);
		else
			m_axis_tready <= 1'b1;
	end

	// monitor and checker
	always @(posedge clk) begin
		walk_result_t want;
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tagged_q.size() == 0) begin
				$error("result word with nothing expected");
				error_count++;
			end else begin
				want = tagged_q.pop_front();
				if (m_axis_tdata[7:0] !== want.option_type) begin
					$error("option_type expected %0d got %0d", want.option_type,
						m_axis_tdata[7:0]);
					error_count++;
				end
				if (m_axis_tuser !== want.byte_role) begin
					$error("byte_role expected %0d got %0d", want.byte_role, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[13:8] !== want.data_index) begin
					$error("data_index expected %0d got %0d", want.data_index,
						m_axis_tdata[13:8]);
					error_count++;
				end
				if (m_axis_tdata[19:14] !== want.data_size) begin
					$error("data_size expected %0d got %0d", want.data_size,
						m_axis_tdata[19:14]);
					error_count++;
				end
				if (m_axis_tdata[20] !== want.option_end) begin
					$error("option_end expected %0d got %0d", want.option_end, m_axis_tdata[20]);
					error_count++;
				end
				if (m_axis_tdata[22:21] !== want.parse_status) begin
					$error("parse_status expected %0d got %0d", want.parse_status,
						m_axis_tdata[22:21]);
					error_count++;
				end
				if (m_axis_tlast !== want.area_end) begin
					$error("area_end expected %0d got %0d", want.area_end, m_axis_tlast);
					error_count++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tagged_q.push_back(walk_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[13:8]));
	end

	initial begin
		logic [1:0] phase, prev_phase;
		// byte before any area
		push_byte(8'hA5, 1'b0, 6'd17);
		// empty area
		push_byte(8'h44, 1'b1, 6'd0);
		// nop, eol, zero-data option, one-data option, multi-byte type on last byte
		push_byte(OPT_NOP, 1'b1, 6'd8);
		push_byte(OPT_EOL, 1'b0, 6'd0);
		push_byte(8'h44, 1'b0, 6'd0);
		push_byte(8'h02, 1'b0, 6'd0);
		push_byte(8'h83, 1'b0, 6'd0);
		push_byte(8'h03, 1'b0, 6'd0);
		push_byte(8'hFF, 1'b0, 6'd0);
		push_byte(8'h07, 1'b0, 6'd0);
		// outside the area after a stop
		push_byte(8'h5A, 1'b0, 6'd63);
		// length below two, then bytes after the stop
		push_byte(8'h89, 1'b1, 6'd5);
		push_byte(8'h01, 1'b0, 6'd0);
		push_byte(8'hFF, 1'b0, 6'd0);
		push_byte(8'h00, 1'b0, 6'd0);
		push_byte(8'h10, 1'b0, 6'd0);
		// option longer than the area
		push_byte(8'h94, 1'b1, 6'd4);
		push_byte(8'h05, 1'b0, 6'd0);
		push_byte(8'h00, 1'b0, 6'd0);
		push_byte(8'hFF, 1'b0, 6'd0);
		// oversized area is clipped, so length 41 overruns
		push_byte(8'h82, 1'b1, 6'd63);
		push_byte(8'h29, 1'b0, 6'd0);
		push_byte(8'h33, 1'b0, 6'd42);

		prev_phase = PH_FULL_RATE;
		while (area_bytes_q.size() < 1475) begin
			if (area_bytes_q.size() < 500)
				phase = PH_SLOW_SINK;
			else if (area_bytes_q.size() < 1000)
				phase = PH_SLOW_SOURCE;
			else
				phase = PH_FULL_RATE;
			add_random_area(phase, phase != prev_phase || $urandom_range(0, 11) == 0);
			prev_phase = phase;
		end

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (area_bytes_q.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (tagged_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/otw_pkg.sv
hdl/otw_step.sv
hdl/ipv4_option_tlv_walker.sv
tb/tb_top.sv
